>>> rtl/core/single_source_shortest_path_defines.svh
// Assertion macros shared by the shortest path block.
`ifndef SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define SSSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled during reset.
`define SSSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sssp_pkg.sv
// Types and constants of the shortest path block.
package sssp_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int DIST_BITS_DEF    = 22;

  localparam int VID_W   = 6;
  localparam int WIN_W   = 16;
  localparam int PDIST_W = 22;
  localparam int CFG_W   = 7;

  localparam logic       REG_VERTEX_COUNT = 1'b0;
  localparam logic       REG_SOURCE       = 1'b1;
  localparam logic [6:0] VCOUNT_RESET     = 7'd64;
  localparam logic [5:0] SOURCE_RESET     = 6'd0;

  typedef struct packed {
    logic [VID_W-1:0] edge_from;
    logic [VID_W-1:0] edge_to;
    logic [WIN_W-1:0] edge_weight;
    logic             last_edge;
  } sssp_in_t;

  typedef struct packed {
    logic [VID_W-1:0]   vertex_index;
    logic [PDIST_W-1:0] path_distance;
    logic [VID_W-1:0]   predecessor;
    logic               has_predecessor;
    logic               reachable;
    logic               final_result;
  } sssp_out_t;

endpackage

>>> rtl/core/single_source_shortest_path.sv
// Dijkstra shortest paths over an undirected weighted graph loaded one edge per transaction.
//
// Each edge transaction is written into the weight store, which has one write port, once
// in each direction (ST_IDLE, then ST_WR2). The transaction marked last then starts the
// search: one sequencer steps a single compare and add unit through the vertices, with a
// read and a compare state per vertex for the minimum scan and a read and an update state
// per vertex for the relaxation. Each result is read, loaded and then held until out_stall
// is low. After the last result, and also after reset, the weight store is cleared one
// entry per cycle, all of its entries (4096 by default), with in_stall held high;
// configuration writes are taken at any time.
module single_source_shortest_path #(
  parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = sssp_pkg::WEIGHT_BITS_DEF,
  parameter int DIST_BITS    = sssp_pkg::DIST_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  sssp_pkg::sssp_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sssp_pkg::sssp_out_t          out_data,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [sssp_pkg::CFG_W-1:0]   cfg_wdata
);
  import sssp_pkg::*;
  `include "single_source_shortest_path_defines.svh"

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int SW  = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
  localparam int WMW = WEIGHT_BITS + 1;
  localparam int DMW = DIST_BITS + VW;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_WR2      = 4'd1;
  localparam logic [3:0] ST_INIT     = 4'd2;
  localparam logic [3:0] ST_SEL_RD   = 4'd3;
  localparam logic [3:0] ST_SEL_CMP  = 4'd4;
  localparam logic [3:0] ST_SETTLE   = 4'd5;
  localparam logic [3:0] ST_REL_RD   = 4'd6;
  localparam logic [3:0] ST_REL_UPD  = 4'd7;
  localparam logic [3:0] ST_EMIT_RD  = 4'd8;
  localparam logic [3:0] ST_EMIT_LD  = 4'd9;
  localparam logic [3:0] ST_EMIT_OUT = 4'd10;
  localparam logic [3:0] ST_CLEAR    = 4'd11;

  logic [3:0]             state_r, state_nxt;
  logic [CFG_W-1:0]       vcount_r, vcount_nxt;
  logic [VID_W-1:0]       source_r, source_nxt;
  logic [CW-1:0]          n_r, n_nxt;
  logic [CW-1:0]          vtx_r, vtx_nxt;
  logic [VW-1:0]          best_r, best_nxt;
  logic [DIST_BITS-1:0]   best_d_r, best_d_nxt;
  logic                   found_r, found_nxt;
  logic [MAX_VERTICES-1:0] reached_r, reached_nxt;
  logic [MAX_VERTICES-1:0] settled_r, settled_nxt;
  logic [VW-1:0]          efrom_r, efrom_nxt;
  logic [VW-1:0]          eto_r, eto_nxt;
  logic [WEIGHT_BITS-1:0] ewt_r, ewt_nxt;
  logic                   eok_r, eok_nxt;
  logic                   elast_r, elast_nxt;
  logic [2*VW-1:0]        clr_r, clr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  sssp_out_t              out_r, out_nxt;

  logic                   wm_we;
  logic [2*VW-1:0]        wm_waddr;
  logic [WMW-1:0]         wm_wdata;
  logic [WMW-1:0]         wm_rdata;
  logic                   dm_we;
  logic [VW-1:0]          dm_waddr;
  logic [DMW-1:0]         dm_wdata;
  logic [DMW-1:0]         dm_rdata;

  logic [VW-1:0]          vi;
  logic                   vtx_last;
  logic [CW-1:0]          n_calc;
  logic                   in_acc;
  logic                   in_ok;
  logic [DIST_BITS-1:0]   rd_dist;
  logic [SW-1:0]          cand_wide;
  logic [DIST_BITS-1:0]   cand;
  logic                   reach_v;

  assign vi       = vtx_r[VW-1:0];
  assign vtx_last = (vtx_r == CW'(n_r - CW'(1)));
  assign in_acc   = in_valid && !in_stall;
  assign in_ok    = (32'(in_data.edge_from) < MAX_VERTICES) &&
                    (32'(in_data.edge_to) < MAX_VERTICES);
  assign rd_dist  = dm_rdata[DMW-1:VW];
  assign reach_v  = reached_r[vi];

  assign cand_wide = SW'(best_d_r) + SW'(wm_rdata[WEIGHT_BITS-1:0]);
  assign cand = (cand_wide > SW'({DIST_BITS{1'b1}})) ? {DIST_BITS{1'b1}}
                                                    : cand_wide[DIST_BITS-1:0];

  always_comb begin
    if (vcount_r == '0) begin
      n_calc = CW'(1);
    end else if (32'(vcount_r) > MAX_VERTICES) begin
      n_calc = CW'(MAX_VERTICES);
    end else begin
      n_calc = CW'(vcount_r);
    end
  end

  sssp_ram #(.AW(2*VW), .DW(WMW)) u_weight_ram (
    .clk   (clk),
    .we    (wm_we),
    .waddr (wm_waddr),
    .wdata (wm_wdata),
    .raddr ({best_r, vi}),
    .rdata (wm_rdata)
  );

  sssp_ram #(.AW(VW), .DW(DMW)) u_dist_ram (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .raddr (vi),
    .rdata (dm_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    vcount_nxt    = vcount_r;
    source_nxt    = source_r;
    n_nxt         = n_r;
    vtx_nxt       = vtx_r;
    best_nxt      = best_r;
    best_d_nxt    = best_d_r;
    found_nxt     = found_r;
    reached_nxt   = reached_r;
    settled_nxt   = settled_r;
    efrom_nxt     = efrom_r;
    eto_nxt       = eto_r;
    ewt_nxt       = ewt_r;
    eok_nxt       = eok_r;
    elast_nxt     = elast_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    wm_we         = 1'b0;
    wm_waddr      = {VW'(in_data.edge_from), VW'(in_data.edge_to)};
    wm_wdata      = {1'b1, WEIGHT_BITS'(in_data.edge_weight)};
    dm_we         = 1'b0;
    dm_waddr      = vi;
    dm_wdata      = {cand, best_r};

    if (cfg_we) begin
      if (cfg_index == REG_VERTEX_COUNT) begin
        vcount_nxt = cfg_wdata;
      end else begin
        source_nxt = cfg_wdata[VID_W-1:0];
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          wm_we     = in_ok;
          efrom_nxt = VW'(in_data.edge_from);
          eto_nxt   = VW'(in_data.edge_to);
          ewt_nxt   = WEIGHT_BITS'(in_data.edge_weight);
          eok_nxt   = in_ok;
          elast_nxt = in_data.last_edge;
          state_nxt = ST_WR2;
        end
      end
      ST_WR2: begin
        // Reverse direction of the same undirected edge.
        wm_we     = eok_r;
        wm_waddr  = {eto_r, efrom_r};
        wm_wdata  = {1'b1, ewt_r};
        state_nxt = elast_r ? ST_INIT : ST_IDLE;
      end
      ST_INIT: begin
        n_nxt       = n_calc;
        vtx_nxt     = '0;
        found_nxt   = 1'b0;
        settled_nxt = '0;
        reached_nxt = '0;
        if (32'(source_r) < 32'(n_calc)) begin
          reached_nxt[VW'(source_r)] = 1'b1;
          dm_we     = 1'b1;
          dm_waddr  = VW'(source_r);
          dm_wdata  = '0;
          state_nxt = ST_SEL_RD;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_SEL_RD: begin
        state_nxt = ST_SEL_CMP;
      end
      ST_SEL_CMP: begin
        if (reach_v && !settled_r[vi] && (!found_r || rd_dist < best_d_r)) begin
          best_nxt   = vi;
          best_d_nxt = rd_dist;
          found_nxt  = 1'b1;
        end
        if (vtx_last) begin
          state_nxt = ST_SETTLE;
        end else begin
          vtx_nxt   = CW'(vtx_r + CW'(1));
          state_nxt = ST_SEL_RD;
        end
      end
      ST_SETTLE: begin
        vtx_nxt = '0;
        if (found_r) begin
          settled_nxt[best_r] = 1'b1;
          state_nxt = ST_REL_RD;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_REL_RD: begin
        state_nxt = ST_REL_UPD;
      end
      ST_REL_UPD: begin
        if (wm_rdata[WMW-1] && !settled_r[vi] && (!reach_v || cand < rd_dist)) begin
          dm_we           = 1'b1;
          reached_nxt[vi] = 1'b1;
        end
        if (vtx_last) begin
          vtx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = ST_SEL_RD;
        end else begin
          vtx_nxt   = CW'(vtx_r + CW'(1));
          state_nxt = ST_REL_RD;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_nxt.vertex_index    = VID_W'(vi);
        out_nxt.path_distance   = reach_v ? PDIST_W'(rd_dist) : '0;
        out_nxt.has_predecessor = reach_v && (32'(vi) != 32'(source_r));
        out_nxt.predecessor     = out_nxt.has_predecessor ?
                                  VID_W'(dm_rdata[VW-1:0]) : '0;
        out_nxt.reachable       = reach_v;
        out_nxt.final_result    = vtx_last;
        out_valid_nxt           = 1'b1;
        state_nxt               = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (vtx_last) begin
            clr_nxt   = '0;
            state_nxt = ST_CLEAR;
          end else begin
            vtx_nxt   = CW'(vtx_r + CW'(1));
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      ST_CLEAR: begin
        wm_we    = 1'b1;
        wm_waddr = clr_r;
        wm_wdata = '0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == {(2*VW){1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      vcount_r    <= VCOUNT_RESET;
      source_r    <= SOURCE_RESET;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      vtx_r       <= '0;
      n_r         <= CW'(1);
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      vcount_r    <= vcount_nxt;
      source_r    <= source_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      vtx_r       <= vtx_nxt;
      n_r         <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r    <= best_nxt;
    best_d_r  <= best_d_nxt;
    reached_r <= reached_nxt;
    settled_r <= settled_nxt;
    efrom_r   <= efrom_nxt;
    eto_r     <= eto_nxt;
    ewt_r     <= ewt_nxt;
    eok_r     <= eok_nxt;
    elast_r   <= elast_nxt;
    out_r     <= out_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SSSP_ASSERT_NOW(a_out_only_emit, out_valid, state_r == ST_EMIT_OUT,
    "result valid outside emission")
  `SSSP_ASSERT_NEXT(a_edge_second_write, in_acc, state_r == ST_WR2,
    "accepted edge not followed by reverse write")
  `SSSP_ASSERT_NOW(a_settle_reached, (state_r == ST_SETTLE) && found_r, reached_r[best_r],
    "settling a vertex that was never reached")
  `SSSP_ASSERT_NOW(a_final_last, out_valid && out_data.final_result, vtx_last,
    "final marker on a vertex other than the last in use")

endmodule

>>> rtl/core/sssp_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module sssp_ram #(
  parameter int AW = 6,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/sssp_checker.sv
// Checker for the shortest path block: predicts every result and compares it as it leaves.
`timescale 1ns / 100ps

module sssp_checker
  import sssp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  sssp_in_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  sssp_out_t            out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   error_count,
  output int                   results_awaited
);

  localparam int NV = MAX_VERTICES_DEF;
  localparam int unsigned DIST_LIMIT = (1 << PDIST_W) - 1;

  bit              edge_known [NV][NV];
  logic [WIN_W-1:0] edge_cost [NV][NV];
  logic [CFG_W-1:0] vertex_count;
  logic [VID_W-1:0] source_vertex;
  sssp_out_t       path_results[$];

  assign results_awaited = path_results.size();

  function automatic void forget_graph();
    foreach (edge_known[a, b]) begin
      edge_known[a][b] = 1'b0;
      edge_cost[a][b]  = '0;
    end
  endfunction

  // Runs the search over the stored graph and queues one result per vertex in use.
  function automatic void predict_paths();
    int          n;
    int          pick;
    int unsigned path_len [NV];
    int          prev [NV];
    bit          settled [NV];
    bit          reached [NV];
    int unsigned cand;
    sssp_out_t   r;
    n = (vertex_count == 0) ? 1 : ((vertex_count > NV) ? NV : int'(vertex_count));
    for (int v = 0; v < NV; v++) begin
      path_len[v] = 0;
      prev[v] = 0;
      settled[v] = 0;
      reached[v] = 0;
    end
    if (source_vertex < n) begin
      reached[source_vertex] = 1;
      for (int rnd = 0; rnd < n; rnd++) begin
        pick = n;
        for (int v = 0; v < n; v++) begin
          if (reached[v] && !settled[v] && (pick == n || path_len[v] < path_len[pick])) pick = v;
        end
        if (pick == n) break;
        settled[pick] = 1;
        for (int v = 0; v < n; v++) begin
          if (!edge_known[pick][v] || settled[v]) continue;
          cand = path_len[pick] + edge_cost[pick][v];
          if (cand > DIST_LIMIT) cand = DIST_LIMIT;
          if (!reached[v] || cand < path_len[v]) begin
            reached[v] = 1;
            path_len[v] = cand;
            prev[v] = pick;
          end
        end
      end
    end
    for (int v = 0; v < n; v++) begin
      r.vertex_index    = VID_W'(v);
      r.reachable       = reached[v];
      r.path_distance   = reached[v] ? PDIST_W'(path_len[v]) : '0;
      r.has_predecessor = reached[v] && (v != source_vertex);
      r.predecessor     = r.has_predecessor ? VID_W'(prev[v]) : '0;
      r.final_result    = (v == n - 1);
      path_results.insert(path_results.size(), r);
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    sssp_out_t want;
    if (!rst_n) begin
      forget_graph();
      vertex_count  = VCOUNT_RESET;
      source_vertex = SOURCE_RESET;
      path_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_VERTEX_COUNT) vertex_count = cfg_wdata;
        else if (cfg_index == REG_SOURCE) source_vertex = cfg_wdata[VID_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (path_results.size() == 0) begin
          $error("result for vertex %0d arrived with none expected", out_data.vertex_index);
          error_count++;
        end else begin
          want = path_results.pop_front();
          check_field("vertex_index", want.vertex_index, out_data.vertex_index);
          check_field("path_distance", want.path_distance, out_data.path_distance);
          check_field("predecessor", want.predecessor, out_data.predecessor);
          check_field("has_predecessor", want.has_predecessor, out_data.has_predecessor);
          check_field("reachable", want.reachable, out_data.reachable);
          check_field("final_result", want.final_result, out_data.final_result);
        end
      end
      if (in_valid && !in_stall) begin
        edge_known[in_data.edge_from][in_data.edge_to] = 1'b1;
        edge_cost[in_data.edge_from][in_data.edge_to]  = in_data.edge_weight;
        edge_known[in_data.edge_to][in_data.edge_from] = 1'b1;
        edge_cost[in_data.edge_to][in_data.edge_from]  = in_data.edge_weight;
        if (in_data.last_edge) begin
          predict_paths();
          forget_graph();
        end
      end
    end
  end

  initial error_count = 0;

endmodule

>>> tb/tb_top.sv
// Top of the shortest path testbench: clock, reset, graph stimulus and the verdict.
`timescale 1ns / 100ps

module tb_top;
  import sssp_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  sssp_in_t         in_data;
  logic             out_valid;
  logic             out_stall;
  sssp_out_t        out_data;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  int               error_count;
  int               results_awaited;
  int               edges_sent;
  int               hold_left;
  bit               quiet;

  single_source_shortest_path i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sssp_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .error_count     (error_count),
    .results_awaited (results_awaited)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // The result side holds stall for a drawn number of cycles after each transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_stall) begin
      if (hold_left == 0) out_stall <= 1'b0;
      else hold_left <= hold_left - 1;
    end else if (out_valid) begin
      int w;
      w = quiet ? 0 : $urandom_range(0, 16);
      if (w > 0) begin
        out_stall <= 1'b1;
        hold_left <= w - 1;
      end
    end
  end

  task automatic write_reg(logic idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Presents one edge after its gap and returns on the edge that accepts it.
  task automatic send_edge(int from, int to, int weight, bit last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{edge_from: VID_W'(from), edge_to: VID_W'(to),
                  edge_weight: WIN_W'(weight), last_edge: last};
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    edges_sent++;
    if (last) in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (results_awaited != 0);
  endtask

  task automatic set_graph(int count, int src);
    write_reg(REG_VERTEX_COUNT, count);
    write_reg(REG_SOURCE, src);
  endtask

  initial begin
    int n;
    int used;
    int num_edges;
    int a;
    int b;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_VERTEX_COUNT;
    cfg_wdata = '0;
    quiet     = 1'b0;
    edges_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Full size from the reset settings: extreme weights, a self loop, an overwritten
    // edge, and a pair of vertices cut off from the source.
    send_edge(0, 1, 65535, 0);
    send_edge(1, 2, 0, 0);
    send_edge(0, 2, 7, 0);
    send_edge(2, 2, 5, 0);
    send_edge(63, 62, 65535, 0);
    send_edge(62, 0, 1, 0);
    send_edge(0, 1, 3, 0);
    send_edge(10, 11, 9, 1);
    wait_drained();
    // A count above the maximum is clamped; source at the top vertex.
    set_graph(127, 63);
    send_edge(63, 0, 65535, 0);
    send_edge(0, 42, 21845, 0);
    send_edge(42, 21, 43690, 1);
    wait_drained();
    // A zero count is taken as one vertex.
    set_graph(0, 0);
    send_edge(0, 0, 4, 1);
    wait_drained();
    // The source lies beyond the vertices in use, so nothing is reached.
    set_graph(5, 9);
    send_edge(1, 2, 3, 0);
    send_edge(9, 4, 1, 1);
    wait_drained();
    // Edges leaving the vertices in use are ignored; equal distances test the tie rule.
    set_graph(4, 3);
    send_edge(3, 40, 1, 0);
    send_edge(40, 0, 1, 0);
    send_edge(3, 1, 2, 0);
    send_edge(3, 2, 2, 0);
    send_edge(1, 0, 5, 0);
    send_edge(2, 0, 5, 1);
    wait_drained();

    while (edges_sent < 420) begin
      quiet = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 11))
        0:       n = 64;
        1:       n = $urandom_range(65, 127);
        2:       n = $urandom_range(0, 1);
        default: n = $urandom_range(2, 12);
      endcase
      used = (n == 0) ? 1 : ((n > 64) ? 64 : n);
      if ($urandom_range(0, 7) == 0 && used < 64) set_graph(n, $urandom_range(used, 63));
      else set_graph(n, $urandom_range(0, used - 1));
      num_edges = $urandom_range(1, 20);
      for (int k = 0; k < num_edges; k++) begin
        if ($urandom_range(0, 6) == 0) begin
          a = $urandom_range(0, 63);
          b = $urandom_range(0, 63);
        end else begin
          a = $urandom_range(0, used - 1);
          b = $urandom_range(0, used - 1);
        end
        send_edge(a, b, $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 65535),
                  k == num_edges - 1);
      end
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (error_count == 0 && results_awaited == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #150_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
